/* rtl/set_assoc_cache_lru_write_through_macros.svh */
// Assertion macros shared by the cache RTL
`ifndef SET_ASSOC_CACHE_LRU_WRITE_THROUGH_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_WRITE_THROUGH_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define SACL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define SACL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/sacl_pkg.sv */
// ---------------------------------------------------------------------------
// sacl_pkg
// Geometry constants, codes and types of the set-associative cache.
// ---------------------------------------------------------------------------
`default_nettype none
package sacl_pkg;
  localparam int unsigned Ways       = 4;
  localparam int unsigned Sets       = 16;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned MemBytes   = 65536;
  localparam int unsigned OffW  = $clog2(BlockBytes);
  localparam int unsigned SetW  = $clog2(Sets);
  localparam int unsigned WayW  = $clog2(Ways);
  localparam int unsigned AddrW = $clog2(MemBytes);
  localparam int unsigned TagW  = AddrW - OffW - SetW;
  localparam int unsigned LineW = SetW + WayW;
  localparam int unsigned DataAddrW = LineW + OffW;
  localparam int unsigned BlkAddrW  = AddrW - OffW;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_FLUSH = 2'd2,
    FUNC_QUERY = 2'd3
  } func_e;

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [7:0]      age;
  } way_meta_t;
endpackage
`default_nettype wire

/* rtl/set_assoc_cache_lru_write_through.sv */
// ---------------------------------------------------------------------------
// set_assoc_cache_lru_write_through
// Four-way LRU cache, write-through, no write-allocate, with backing store.
// ---------------------------------------------------------------------------
// Usage:
//  Request channel: req_valid_i / req_stall_o with func_i, address_i and
//  write_data_i. Response channel: rsp_valid_o / rsp_stall_i with read_data_o,
//  hit_o, access_count_o and miss_count_o; one response per request, in order.
//  Path: a write, flush or query passes the tag read and the result
//  register; a read hit passes the tag read, the data read and the result
//  register. A read miss adds a block fill of BlockBytes bytes, paced by
//  the one backing memory port (one byte per cycle).
//  Throughput: one request at a time; the next request is taken the cycle
//  after the previous one reaches the response register. A stalled
//  response does not hold off the next request, which runs up to the
//  response register and waits there.
//  Reset: valid bits, ages and counters clear at once. The backing memory is
//  zeroed by a clearing pass over all MemBytes addresses after reset, during
//  which no request is taken. A flush clears all lines at once: per-line
//  valid bits and ages sit in flip-flops.
//  Stall: while rsp_stall_i is high the response holds and no new request
//  that would overwrite it completes.
// ---------------------------------------------------------------------------
`default_nettype none
module set_assoc_cache_lru_write_through (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      req_valid_i,
  output logic                           req_stall_o,
  input  wire logic [1:0]                func_i,
  input  wire logic [sacl_pkg::AddrW-1:0] address_i,
  input  wire logic [7:0]                write_data_i,
  output logic                           rsp_valid_o,
  input  wire logic                      rsp_stall_i,
  output logic [7:0]                     read_data_o,
  output logic                           hit_o,
  output logic [31:0]                    access_count_o,
  output logic [31:0]                    miss_count_o
);
  import sacl_pkg::*;
  `include "set_assoc_cache_lru_write_through_macros.svh"

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_LOOK, ST_FILL, ST_DATA, ST_DONE
  } state_e;

  localparam int unsigned Lines = Sets * Ways;

  // memories; tags are held one word per set, all ways side by side
  logic [7:0]      mem_q  [MemBytes];
  logic [7:0]      data_q [Lines*BlockBytes];
  logic [Ways-1:0][TagW-1:0] tag_q [Sets];
  logic [7:0]      mem_rd_q, data_rd_q;
  logic [Ways-1:0][TagW-1:0] tag_rd_q;

  // flip-flop metadata, ages grouped per set
  logic [Lines-1:0] valid_q;
  logic [Ways-1:0][7:0] age_q [Sets];

  state_e          state_q;
  logic [AddrW-1:0] clr_q;
  logic [OffW:0]    fcnt_q;
  logic [1:0]       func_q;
  logic [AddrW-1:0] addr_q;
  logic [7:0]       wdata_q;
  logic [WayW-1:0]  way_q;
  logic             hit_q;
  logic [31:0]      acc_q, miss_q;

  logic [OffW-1:0] off;
  logic [SetW-1:0] set_idx;
  logic [TagW-1:0] tag;
  assign off     = addr_q[OffW-1:0];
  assign set_idx = addr_q[OffW +: SetW];
  assign tag     = addr_q[AddrW-1 -: TagW];

  // hit search and victim choice over the registered tag read
  logic            lk_hit;
  logic [WayW-1:0] lk_way, vic_way;
  always_comb begin
    logic found, inv;
    logic [7:0] best_age;
    logic [LineW-1:0] ln;
    found = 1'b0; inv = 1'b0; lk_way = '0; vic_way = '0; best_age = '0;
    for (int j = 0; j < Ways; j++) begin
      ln = {set_idx, WayW'(j)};
      if (!found && valid_q[ln] && tag_rd_q[j] == tag) begin
        found = 1'b1; lk_way = WayW'(j);
      end
    end
    for (int j = 0; j < Ways; j++) begin
      ln = {set_idx, WayW'(j)};
      if (!inv && !valid_q[ln]) begin
        inv = 1'b1; vic_way = WayW'(j);
      end
    end
    if (!inv) begin
      for (int j = 0; j < Ways; j++) begin
        if (j == 0 || age_q[set_idx][j] > best_age) begin
          best_age = age_q[set_idx][j]; vic_way = WayW'(j);
        end
      end
    end
    lk_hit = found;
  end

  logic accept;
  assign req_stall_o = (state_q != ST_IDLE);
  assign accept      = req_valid_i && !req_stall_o;

  // counter helpers
  logic [31:0] acc_inc, miss_inc;
  assign acc_inc  = (acc_q == '1) ? acc_q : acc_q + 32'd1;
  assign miss_inc = (miss_q == '1) ? miss_q : miss_q + 32'd1;

  // memory ports
  logic [AddrW-1:0] mem_raddr;
  logic [BlkAddrW-1:0] blk;
  assign blk = addr_q[AddrW-1:OffW];
  assign mem_raddr = {blk, fcnt_q[OffW-1:0]};
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      mem_q[clr_q] <= '0;
    end else if (state_q == ST_LOOK && func_q == FUNC_WRITE) begin
      mem_q[addr_q] <= wdata_q;
    end
    mem_rd_q <= mem_q[mem_raddr];
  end

  logic             dwe;
  logic [DataAddrW-1:0] dwa, dra;
  logic [7:0]       dwd;
  always_comb begin
    dwe = 1'b0; dwa = {set_idx, way_q, off}; dwd = wdata_q;
    if (state_q == ST_LOOK && func_q == FUNC_WRITE && lk_hit) begin
      dwe = 1'b1; dwa = {set_idx, lk_way, off};
    end else if (state_q == ST_FILL && fcnt_q != '0) begin
      dwe = 1'b1; dwa = {set_idx, way_q, OffW'(fcnt_q - 1'b1)}; dwd = mem_rd_q;
    end
  end
  // on a read hit the way is known in ST_LOOK; read data in the next cycle
  assign dra = {set_idx, (state_q == ST_LOOK) ? lk_way : way_q, off};
  always_ff @(posedge clk_i) begin
    if (dwe) data_q[dwa] <= dwd;
    data_rd_q <= data_q[dra];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOOK && func_q == FUNC_READ && !lk_hit) begin
      tag_q[set_idx][vic_way] <= tag;
    end
    tag_rd_q <= tag_q[address_i[OffW +: SetW]];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [WayW-1:0]  tw;
    logic [LineW-1:0] ln;
    if (!rst_ni) begin
      state_q <= ST_CLEAR; clr_q <= '0; fcnt_q <= '0;
      valid_q <= '0; acc_q <= '0; miss_q <= '0;
      for (int i = 0; i < Sets; i++) age_q[i] <= '0;
      rsp_valid_o <= 1'b0; hit_q <= 1'b0; way_q <= '0;
      func_q <= FUNC_QUERY; addr_q <= '0; wdata_q <= '0;
      read_data_o <= '0; hit_o <= 1'b0; access_count_o <= '0; miss_count_o <= '0;
    end else begin
      if (rsp_valid_o && !rsp_stall_i && state_q != ST_DONE) rsp_valid_o <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            func_q <= func_i; addr_q <= address_i; wdata_q <= write_data_i;
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          unique case (func_q)
            FUNC_READ, FUNC_WRITE: begin
              acc_q <= acc_inc;
              if (!lk_hit) miss_q <= miss_inc;
              hit_q <= lk_hit;
              tw = lk_hit ? lk_way : vic_way;
              way_q <= tw;
              if (func_q == FUNC_READ || lk_hit) begin
                for (int j = 0; j < Ways; j++) begin
                  ln = {set_idx, WayW'(j)};
                  if (WayW'(j) == tw) age_q[set_idx][j] <= '0;
                  else if (valid_q[ln] && age_q[set_idx][j] != 8'hFF)
                    age_q[set_idx][j] <= age_q[set_idx][j] + 8'd1;
                end
              end
              if (func_q == FUNC_READ && !lk_hit) begin
                valid_q[{set_idx, vic_way}] <= 1'b1;
                fcnt_q <= '0;
                state_q <= ST_FILL;
              end else begin
                state_q <= (func_q == FUNC_READ) ? ST_DATA : ST_DONE;
              end
            end
            FUNC_FLUSH: begin
              hit_q <= 1'b0;
              valid_q <= '0; acc_q <= '0; miss_q <= '0;
              for (int i = 0; i < Sets; i++) age_q[i] <= '0;
              state_q <= ST_DONE;
            end
            default: begin
              hit_q <= 1'b0;
              state_q <= ST_DONE;
            end
          endcase
        end
        ST_FILL: begin
          fcnt_q <= fcnt_q + 1'b1;
          if (fcnt_q == (OffW+1)'(BlockBytes)) state_q <= ST_DATA;
        end
        ST_DATA: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!rsp_valid_o || !rsp_stall_i) begin
            rsp_valid_o <= 1'b1;
            read_data_o <= (func_q == FUNC_READ) ? data_rd_q : 8'd0;
            hit_o <= hit_q;
            access_count_o <= acc_q;
            miss_count_o <= miss_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `SACL_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, state_q != ST_IDLE, !accept,
                   "request taken while busy")
  `SACL_ASSERT_NXT(a_rsp_holds, clk_i, rst_ni, rsp_valid_o && rsp_stall_i,
                   rsp_valid_o && $stable(read_data_o), "stalled response lost")
  `SACL_ASSERT_IMP(a_miss_le_acc, clk_i, rst_ni, state_q == ST_IDLE, miss_q <= acc_q,
                   "misses exceed accesses")
endmodule
`default_nettype wire
